FILE: rtl/core/ltfq_pkg.sv
// Package for the linked task FIFO queue: request and response payloads,
// operation and slot status codes, controller states and control structs.
// No dependencies.
package ltfq_pkg;

	// Fixed widths of the request and response fields.
	localparam int FUNC_W = 2;
	localparam int SLOT_W = 5;

	// Operation codes carried in a request.
	typedef enum logic [FUNC_W-1:0] {
		FN_ENQ     = 2'd0,
		FN_DEQ     = 2'd1,
		FN_REMOVE  = 2'd2,
		FN_RELEASE = 2'd3
	} func_t;

	// Per-slot status.
	typedef enum logic [1:0] {
		ST_UNLINKED = 2'd0,
		ST_QUEUED   = 2'd1,
		ST_RUNNING  = 2'd2
	} status_t;

	// Request payload.
	typedef struct packed {
		func_t             func;
		logic [SLOT_W-1:0] slot_id;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot_out;
		logic              now_empty;
	} rsp_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_WALK
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the request
		logic fetch;   // issue table reads, start the walk at the head
		logic exec;    // finish the request (remove: slot not found)
		logic step;    // follow one link of the remove walk
		logic rm_hit;  // remove walk found the slot: splice it out
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  skip_walk;  // queue empty or slot out of range
		logic  walk_hit;   // current walk node is the slot to remove
		logic  walk_end;   // walk must stop here
	} stat_t;

endpackage

FILE: rtl/core/ltfq_ctrl.sv
// Controller state machine of the linked task FIFO queue.
// Depends on ltfq_pkg.
module ltfq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ltfq_pkg::stat_t stat,
	output ltfq_pkg::cmd_t cmd,
	output logic           busy
);

	ltfq_pkg::state_t state_q;
	ltfq_pkg::state_t state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ltfq_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ltfq_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = ltfq_pkg::S_FETCH;
				end
			end
			ltfq_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
				if (stat.func == ltfq_pkg::FN_REMOVE && !stat.skip_walk) begin
					state_n = ltfq_pkg::S_WALK;
				end else begin
					state_n = ltfq_pkg::S_EXEC;
				end
			end
			ltfq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_n  = ltfq_pkg::S_IDLE;
			end
			ltfq_pkg::S_WALK: begin
				if (stat.walk_hit) begin
					cmd.rm_hit = 1'b1;
					state_n    = ltfq_pkg::S_IDLE;
				end else if (stat.walk_end) begin
					cmd.exec = 1'b1;
					state_n  = ltfq_pkg::S_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_n = ltfq_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ltfq_pkg::S_IDLE);

endmodule

FILE: rtl/core/ltfq_datapath.sv
// Datapath of the linked task FIFO queue: link and status tables, head,
// tail and empty registers, remove walk registers and the response register.
// Depends on ltfq_pkg.
module ltfq_datapath #(
	parameter int NUM_SLOTS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ltfq_pkg::req_t  req,
	input  ltfq_pkg::cmd_t  cmd,
	output ltfq_pkg::stat_t stat,
	output logic            done,
	output ltfq_pkg::rsp_t  rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int WW    = (IDX_W > ltfq_pkg::SLOT_W) ? IDX_W : ltfq_pkg::SLOT_W;
	localparam int SW    = $clog2(NUM_SLOTS + 1);

	// Tables.
	logic [IDX_W-1:0]  link_mem [NUM_SLOTS];
	ltfq_pkg::status_t stat_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] stat_vld_q;

	// Request and queue registers.
	ltfq_pkg::req_t   req_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic             empty_q;

	// Walk registers.
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] pred_q;
	logic             has_pred_q;
	logic [SW-1:0]    steps_q;

	// Table read data.
	logic [IDX_W-1:0]  link_rd_q;
	ltfq_pkg::status_t stat_mem_rd_q;
	logic              vld_rd_q;
	ltfq_pkg::status_t stat_rd;

	// Response register.
	logic           done_q;
	ltfq_pkg::rsp_t rsp_q;

	// Decoded request.
	logic [WW-1:0]    id_w;
	logic [IDX_W-1:0] s_idx;
	logic             in_range;
	logic [WW-1:0]    head_w;

	// Next values and table writes.
	logic                      ok;
	logic [ltfq_pkg::SLOT_W-1:0] slot_o;
	logic                      empty_n;
	logic [IDX_W-1:0]          head_n;
	logic [IDX_W-1:0]          tail_n;
	logic                      link_we;
	logic [IDX_W-1:0]          link_wa;
	logic [IDX_W-1:0]          link_wd;
	logic [IDX_W-1:0]          link_ra;
	logic                      stat_we;
	logic [IDX_W-1:0]          stat_wa;
	ltfq_pkg::status_t         stat_wd;

	// Walk conditions.
	logic walk_bound;
	logic walk_oor;

	assign id_w     = WW'(req_q.slot_id);
	assign s_idx    = id_w[IDX_W-1:0];
	assign in_range = int'(req_q.slot_id) < NUM_SLOTS;
	assign head_w   = WW'(head_q);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Link table: one registered read, one write. During the walk the read
	// follows the link just returned, so each cycle sees link_next[cur].
	assign link_ra = cmd.step ? link_rd_q : head_q;

	always_ff @(posedge clk) begin
		link_rd_q <= link_mem[link_ra];
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

	// Status table with per-slot valid bits; an unwritten slot reads unlinked.
	always_ff @(posedge clk) begin
		stat_mem_rd_q <= stat_mem[s_idx];
		if (stat_we) begin
			stat_mem[stat_wa] <= stat_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_vld_q <= '0;
			vld_rd_q   <= 1'b0;
		end else begin
			vld_rd_q <= stat_vld_q[s_idx];
			if (stat_we) begin
				stat_vld_q[stat_wa] <= 1'b1;
			end
		end
	end

	assign stat_rd = vld_rd_q ? stat_mem_rd_q : ltfq_pkg::ST_UNLINKED;

	// Operation outcome, queue updates and table writes.
	always_comb begin
		ok      = 1'b0;
		slot_o  = req_q.slot_id;
		empty_n = empty_q;
		head_n  = head_q;
		tail_n  = tail_q;
		link_we = 1'b0;
		link_wa = tail_q;
		link_wd = s_idx;
		stat_we = 1'b0;
		stat_wa = s_idx;
		stat_wd = ltfq_pkg::ST_UNLINKED;
		if (cmd.rm_hit) begin
			// Splice the found slot out; link_rd_q holds its next pointer.
			ok      = 1'b1;
			stat_we = 1'b1;
			if (!has_pred_q) begin
				if (s_idx == tail_q) begin
					empty_n = 1'b1;
				end else begin
					head_n = link_rd_q;
				end
			end else begin
				if (s_idx == tail_q) begin
					tail_n = pred_q;
				end else begin
					link_we = 1'b1;
					link_wa = pred_q;
					link_wd = link_rd_q;
				end
			end
		end else if (cmd.exec) begin
			case (req_q.func)
				ltfq_pkg::FN_ENQ: begin
					if (in_range && stat_rd == ltfq_pkg::ST_UNLINKED) begin
						ok      = 1'b1;
						stat_we = 1'b1;
						stat_wd = ltfq_pkg::ST_QUEUED;
						tail_n  = s_idx;
						empty_n = 1'b0;
						if (empty_q) begin
							head_n = s_idx;
						end else begin
							link_we = 1'b1;
						end
					end
				end
				ltfq_pkg::FN_DEQ: begin
					if (!empty_q) begin
						ok      = 1'b1;
						slot_o  = head_w[ltfq_pkg::SLOT_W-1:0];
						stat_we = 1'b1;
						stat_wa = head_q;
						stat_wd = ltfq_pkg::ST_RUNNING;
						if (head_q == tail_q) begin
							empty_n = 1'b1;
						end else begin
							head_n = link_rd_q;
						end
					end
				end
				ltfq_pkg::FN_REMOVE: begin
					// Not found: the slot still becomes unlinked.
					stat_we = in_range;
				end
				ltfq_pkg::FN_RELEASE: begin
					if (in_range && stat_rd == ltfq_pkg::ST_RUNNING) begin
						ok      = 1'b1;
						stat_we = 1'b1;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	// Queue registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			empty_q <= empty_n;
		end
	end

	// Remove walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			pred_q     <= '0;
			has_pred_q <= 1'b0;
			steps_q    <= '0;
		end else if (cmd.fetch) begin
			cur_q      <= head_q;
			has_pred_q <= 1'b0;
			steps_q    <= '0;
		end else if (cmd.step) begin
			pred_q     <= cur_q;
			cur_q      <= link_rd_q;
			has_pred_q <= 1'b1;
			steps_q    <= steps_q + SW'(1);
		end
	end

	// Walk status toward the controller.
	assign walk_bound = (steps_q == SW'(NUM_SLOTS));
	assign walk_oor   = int'(cur_q) >= NUM_SLOTS;

	always_comb begin
		stat.func      = req_q.func;
		stat.skip_walk = empty_q || !in_range;
		stat.walk_hit  = !walk_bound && !walk_oor && (cur_q == s_idx);
		stat.walk_end  = walk_bound || walk_oor || (cur_q == tail_q);
	end

	// Response register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.rm_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.rm_hit) begin
			rsp_q.ok        <= ok;
			rsp_q.slot_out  <= slot_o;
			rsp_q.now_empty <= empty_n;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/core/linked_task_fifo_queue_core.sv
// Top level of the linked task FIFO queue: controller plus datapath.
// Depends on ltfq_pkg, ltfq_ctrl and ltfq_datapath.
//
//   channel   | handshake          | payload         | accepted when
//   ----------+--------------------+-----------------+-----------------------
//   request   | start / busy       | req  (req_t)    | start && !busy at clk
//   response  | done (one cycle)   | rsp  (rsp_t)    | every cycle done is high
//
// An accepted request runs through the fetch state and then the exec state. A remove
// with an in-range slot and a non-empty queue walks instead, one link per cycle from the
// head, and stops at the slot, at the tail or when NUM_SLOTS links have been walked.
// Done is registered from the final step and is high as the block returns to idle.
// Reset clears the status valid bits, head, tail and the empty flag at once, with
// no clearing pass. The response side cannot stall.
module linked_task_fifo_queue_core #(
	parameter int NUM_SLOTS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ltfq_pkg::req_t req,
	output logic           done,
	output ltfq_pkg::rsp_t rsp
);

	ltfq_pkg::cmd_t  cmd;
	ltfq_pkg::stat_t stat;

	// Sequencing.
	ltfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Tables and queue registers.
	ltfq_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

FILE: rtl/core/ltfq_checker.sv
// Port-level checker for the linked task FIFO queue, bound to the top level.
// Depends on ltfq_pkg and linked_task_fifo_queue_core.
module ltfq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input ltfq_pkg::req_t req,
	input logic           done,
	input ltfq_pkg::rsp_t rsp
);

	// An accepted request makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted request");

	// No response in the cycle right after a request is accepted.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("response in the cycle after acceptance");

	// A response only appears as the block goes idle.
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("response without the end of a busy period");

	// Every end of a busy period delivers a response.
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy period ended without a response");

endmodule

bind linked_task_fifo_queue_core ltfq_checker u_ltfq_checker (.*);
